// ----- rtl/scpf_pkg.sv -----
// Shared types and constants for the sync/checksum packet framer.
package scpf_pkg;

    // Default packet length in bytes
    localparam int PACKET_BYTES_DEF = 44;

    // Register reset values
    localparam logic [7:0] SYNC_VALUE_RESET = 8'h00;
    localparam logic [7:0] MESSAGE_ID_RESET = 8'hA2;

    // Depth of the packet descriptor queue between front and back
    localparam int DESC_DEPTH = 4;

    // Depth of the output register FIFO in the back end
    localparam int OUT_DEPTH = 2;

    // Register map, decoded on paddr[2]
    typedef enum logic {
        REG_SYNC_VALUE = 1'b0,
        REG_MESSAGE_ID = 1'b1
    } reg_index_t;

    // Input transfer payload
    typedef struct packed {
        logic [7:0] rx_byte;
        logic       overrun;
    } in_item_t;

    // Output transfer payload
    typedef struct packed {
        logic [7:0]  packet_byte;
        logic        last_of_packet;
        logic [31:0] good_packets;
    } out_item_t;

    // Configuration seen by the front end
    typedef struct packed {
        logic [7:0] sync_value;
        logic [7:0] message_id;
    } cfg_t;

endpackage

// ----- rtl/sync_checksum_packet_framer.sv -----
// Top level: register port, front end, descriptor queue and back end.
// Accepts one byte per cycle; a verified packet drains at one byte per cycle
// while out_ready is high, via the queue, store read register and output FIFO.
// The input stalls only while the output is held off long enough to fill the
// 2**(clog2(PACKET_BYTES)+1)-byte packet store or the 4-entry descriptor queue.
// Reset (rst_n low, asynchronous) empties the window, queue and output, clears
// the packet count and loads sync_value 0x00 and message_id 0xA2.
module sync_checksum_packet_framer
    import scpf_pkg::*;
#(
    parameter int PACKET_BYTES = PACKET_BYTES_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        in_valid,
    output logic        in_ready,
    input  in_item_t    in_item,
    output logic        out_valid,
    input  logic        out_ready,
    output out_item_t   out_item
);

    localparam int AW = $clog2(PACKET_BYTES) + 1;
    localparam int PW = AW + 1;

    logic [7:0]    sync_reg;
    logic [7:0]    msg_id_reg;
    logic          wr_en;
    reg_index_t    reg_sel;
    cfg_t          cfg;

    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [7:0]    mem_wdata;
    logic [PW-1:0] wr_ptr;
    logic          mem_full;
    logic          desc_push;
    logic [PW-1:0] desc_start;
    logic [31:0]   desc_count;
    logic          desc_pop;
    logic          desc_valid;
    logic          desc_full;
    logic [PW-1:0] head_start;
    logic [31:0]   head_count;

    // Register port
    assign pready  = 1'b1;
    assign reg_sel = reg_index_t'(paddr[2]);
    assign wr_en   = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sync_reg   <= SYNC_VALUE_RESET;
            msg_id_reg <= MESSAGE_ID_RESET;
        end
        else if (wr_en)
        begin
            case (reg_sel)
                REG_SYNC_VALUE: sync_reg   <= pwdata[7:0];
                REG_MESSAGE_ID: msg_id_reg <= pwdata[7:0];
                default:        sync_reg   <= sync_reg;
            endcase
        end
    end

    always_comb
    begin
        case (reg_sel)
            REG_SYNC_VALUE: prdata = {24'h000000, sync_reg};
            REG_MESSAGE_ID: prdata = {24'h000000, msg_id_reg};
            default:        prdata = '0;
        endcase
    end

    assign cfg.sync_value = sync_reg;
    assign cfg.message_id = msg_id_reg;

    scpf_front #(
        .PACKET_BYTES (PACKET_BYTES),
        .AW           (AW)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_item    (in_item),
        .mem_full   (mem_full),
        .desc_full  (desc_full),
        .mem_we     (mem_we),
        .mem_waddr  (mem_waddr),
        .mem_wdata  (mem_wdata),
        .wr_ptr     (wr_ptr),
        .desc_push  (desc_push),
        .desc_start (desc_start),
        .desc_count (desc_count)
    );

    scpf_queue #(
        .PW (PW)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (desc_push),
        .push_start (desc_start),
        .push_count (desc_count),
        .pop        (desc_pop),
        .valid      (desc_valid),
        .full       (desc_full),
        .head_start (head_start),
        .head_count (head_count)
    );

    scpf_back #(
        .PACKET_BYTES (PACKET_BYTES),
        .AW           (AW)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .mem_we     (mem_we),
        .mem_waddr  (mem_waddr),
        .mem_wdata  (mem_wdata),
        .wr_ptr     (wr_ptr),
        .mem_full   (mem_full),
        .desc_valid (desc_valid),
        .desc_start (head_start),
        .desc_count (head_count),
        .desc_pop   (desc_pop),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_item   (out_item)
    );

endmodule

// ----- rtl/scpf_front.sv -----
// Front end: sliding window, running word sums and packet checks.
module scpf_front
    import scpf_pkg::*;
#(
    parameter int PACKET_BYTES = PACKET_BYTES_DEF,
    parameter int AW           = 7
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  cfg_t            cfg,
    input  logic            in_valid,
    output logic            in_ready,
    input  in_item_t        in_item,
    input  logic            mem_full,
    input  logic            desc_full,
    output logic            mem_we,
    output logic [AW-1:0]   mem_waddr,
    output logic [7:0]      mem_wdata,
    output logic [AW:0]     wr_ptr,
    output logic            desc_push,
    output logic [AW:0]     desc_start,
    output logic [31:0]     desc_count
);

    localparam int N          = PACKET_BYTES;
    // Bytes covered by the word sum (even count, oldest first)
    localparam int SUM_BYTES  = 2 * ((N - 1) / 2);
    // Age at which a byte joins the summed region
    localparam int ENTER_AGE  = N - SUM_BYTES;
    localparam int ENTER_TAP  = ENTER_AGE - 1;
    localparam int FW         = $clog2(N + 1);
    localparam int PW         = AW + 1;
    localparam logic ENTER_PAR  = 1'(ENTER_AGE % 2);
    localparam logic OLDEST_PAR = 1'((N - 1) % 2);

    // Byte history, index 0 is the most recent stored byte
    logic [7:0]    sr_reg   [N-1];
    logic [7:0]    sr_next  [N-1];
    logic [FW-1:0] fill_reg, fill_next;
    // Sums of summed-region bytes, split by stream index parity
    logic [15:0]   sum_reg  [2];
    logic [15:0]   sum_next [2];
    logic [15:0]   sum_add  [2];
    logic          ph_reg, ph_next;
    logic [PW-1:0] wr_reg, wr_next;
    logic [31:0]   count_reg, count_next;

    logic          accept;
    logic          store;
    logic [FW-1:0] fill_inc;
    logic          enter_ok;
    logic          enter_par;
    logic          old_par;
    logic [7:0]    oldest;
    logic [15:0]   calc;
    logic [15:0]   got;
    logic          full;
    logic          frame_ok;

    assign in_ready = !mem_full && !desc_full;
    assign accept   = in_valid && in_ready;
    assign store    = accept && !in_item.overrun;

    // Window checks on the byte arriving now
    always_comb
    begin
        fill_inc  = fill_reg + FW'(1);
        enter_ok  = fill_reg >= FW'(ENTER_AGE);
        enter_par = ph_reg ^ ENTER_PAR;
        for (int p = 0; p < 2; p++)
        begin
            sum_add[p] = sum_reg[p] +
                         ((enter_ok && (enter_par == 1'(p))) ?
                          {8'h00, sr_reg[ENTER_TAP]} : 16'h0000);
        end
        old_par  = ph_reg ^ OLDEST_PAR;
        oldest   = sr_reg[N-2];
        calc     = sum_add[old_par] + {sum_add[!old_par][7:0], 8'h00};
        got      = {in_item.rx_byte, sr_reg[0]};
        full     = fill_inc == FW'(N);
        frame_ok = full && (oldest == cfg.sync_value) &&
                   (sr_reg[N-3] == cfg.message_id) && (calc == got);
    end

    // Next state of window bookkeeping
    always_comb
    begin
        fill_next  = fill_reg;
        sum_next   = sum_reg;
        ph_next    = ph_reg;
        wr_next    = wr_reg;
        count_next = count_reg;
        sr_next    = sr_reg;
        if (accept)
        begin
            if (in_item.overrun)
            begin
                fill_next   = '0;
                sum_next[0] = '0;
                sum_next[1] = '0;
            end
            else
            begin
                sr_next[0] = in_item.rx_byte;
                for (int k = 1; k < N - 1; k++)
                begin
                    sr_next[k] = sr_reg[k-1];
                end
                ph_next = !ph_reg;
                wr_next = wr_reg + PW'(1);
                if (frame_ok)
                begin
                    fill_next   = '0;
                    sum_next[0] = '0;
                    sum_next[1] = '0;
                    count_next  = count_reg + 32'd1;
                end
                else if (full)
                begin
                    // drop the oldest byte and slide on by one
                    fill_next         = FW'(N - 1);
                    sum_next          = sum_add;
                    sum_next[old_par] = sum_add[old_par] - {8'h00, oldest};
                end
                else
                begin
                    fill_next = fill_inc;
                    sum_next  = sum_add;
                end
            end
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg   <= '0;
            sum_reg[0] <= '0;
            sum_reg[1] <= '0;
            ph_reg     <= 1'b0;
            wr_reg     <= '0;
            count_reg  <= '0;
        end
        else
        begin
            fill_reg  <= fill_next;
            sum_reg   <= sum_next;
            ph_reg    <= ph_next;
            wr_reg    <= wr_next;
            count_reg <= count_next;
        end
    end

    // Byte history, payload only
    always_ff @(posedge clk)
    begin
        sr_reg <= sr_next;
    end

    // Packet store write port and descriptor push
    assign mem_we     = store;
    assign mem_waddr  = wr_reg[AW-1:0];
    assign mem_wdata  = in_item.rx_byte;
    assign wr_ptr     = wr_reg;
    assign desc_push  = store && frame_ok;
    assign desc_start = wr_reg - PW'(N - 1);
    assign desc_count = count_reg + 32'd1;

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FW'(N))
        else $error("window fill above packet length");

endmodule

// ----- rtl/scpf_queue.sv -----
// Descriptor queue of verified packets waiting to be drained.
module scpf_queue
    import scpf_pkg::*;
#(
    parameter int PW = 8
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  logic [PW-1:0] push_start,
    input  logic [31:0]   push_count,
    input  logic          pop,
    output logic          valid,
    output logic          full,
    output logic [PW-1:0] head_start,
    output logic [31:0]   head_count
);

    localparam int QAW = $clog2(DESC_DEPTH);
    localparam int LW  = $clog2(DESC_DEPTH + 1);

    logic [PW-1:0]  start_reg [DESC_DEPTH];
    logic [31:0]    cnt_reg   [DESC_DEPTH];
    logic [QAW-1:0] head_reg, head_next;
    logic [QAW-1:0] tail_reg, tail_next;
    logic [LW-1:0]  level_reg, level_next;

    assign valid      = level_reg != '0;
    assign full       = level_reg == LW'(DESC_DEPTH);
    assign head_start = start_reg[head_reg];
    assign head_count = cnt_reg[head_reg];

    // Pointer and level update
    always_comb
    begin
        head_next  = head_reg + QAW'(pop);
        tail_next  = tail_reg + QAW'(push);
        level_next = level_reg + LW'(push) - LW'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            level_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            level_reg <= level_next;
        end
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            start_reg[tail_reg] <= push_start;
            cnt_reg[tail_reg]   <= push_count;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (!full || pop))
        else $error("descriptor pushed into full queue");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> valid)
        else $error("descriptor popped from empty queue");

endmodule

// ----- rtl/scpf_back.sv -----
// Back end: packet byte store and drain to the output channel.
module scpf_back
    import scpf_pkg::*;
#(
    parameter int PACKET_BYTES = PACKET_BYTES_DEF,
    parameter int AW           = 7
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          mem_we,
    input  logic [AW-1:0] mem_waddr,
    input  logic [7:0]    mem_wdata,
    input  logic [AW:0]   wr_ptr,
    output logic          mem_full,
    input  logic          desc_valid,
    input  logic [AW:0]   desc_start,
    input  logic [31:0]   desc_count,
    output logic          desc_pop,
    output logic          out_valid,
    input  logic          out_ready,
    output out_item_t     out_item
);

    localparam int N     = PACKET_BYTES;
    localparam int PW    = AW + 1;
    localparam int DEPTH = 2 ** AW;
    localparam int FW    = $clog2(N + 1);
    localparam int OAW   = $clog2(OUT_DEPTH);
    localparam int OLW   = $clog2(OUT_DEPTH + 1);

    // Packet byte store
    logic [7:0]      mem [DEPTH];
    logic [7:0]      mem_q_reg;

    // Drain control
    logic            active_reg, active_next;
    logic [PW-1:0]   rd_reg, rd_next;
    logic [FW-1:0]   rem_reg, rem_next;
    logic [31:0]     cnt_reg, cnt_next;

    // Read data alignment
    logic            rdv_reg;
    logic            rdl_reg;
    logic [31:0]     rdc_reg;

    // Output FIFO
    out_item_t       of_reg [OUT_DEPTH];
    logic [OAW-1:0]  of_head_reg, of_head_next;
    logic [OLW-1:0]  of_level_reg, of_level_next;
    logic [OAW-1:0]  of_tail;

    logic            pop_out;
    logic            credit_ok;
    logic            issue;
    logic            last_issue;

    assign pop_out    = (of_level_reg != '0) && out_ready;
    assign credit_ok  = (OLW'(of_level_reg) + OLW'(rdv_reg) - OLW'(pop_out))
                        < OLW'(OUT_DEPTH);
    assign issue      = active_reg && credit_ok;
    assign last_issue = rem_reg == FW'(1);
    assign desc_pop   = desc_valid && (!active_reg || (issue && last_issue));

    // Writer must not overtake the oldest unread byte
    assign mem_full   = active_reg && ((wr_ptr - rd_reg) == PW'(DEPTH));

    // Drain sequencing
    always_comb
    begin
        active_next = active_reg;
        rd_next     = rd_reg;
        rem_next    = rem_reg;
        cnt_next    = cnt_reg;
        if (issue)
        begin
            rd_next  = rd_reg + PW'(1);
            rem_next = rem_reg - FW'(1);
            if (last_issue)
            begin
                active_next = 1'b0;
            end
        end
        if (desc_pop)
        begin
            active_next = 1'b1;
            rd_next     = desc_start;
            rem_next    = FW'(N);
            cnt_next    = desc_count;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            rd_reg     <= '0;
            rem_reg    <= '0;
            cnt_reg    <= '0;
            rdv_reg    <= 1'b0;
        end
        else
        begin
            active_reg <= active_next;
            rd_reg     <= rd_next;
            rem_reg    <= rem_next;
            cnt_reg    <= cnt_next;
            rdv_reg    <= issue;
        end
    end

    // Store write and registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (issue)
        begin
            mem_q_reg <= mem[rd_reg[AW-1:0]];
            rdl_reg   <= last_issue;
            rdc_reg   <= cnt_reg;
        end
    end

    // Output FIFO control
    always_comb
    begin
        of_tail       = of_head_reg + of_level_reg[OAW-1:0];
        of_head_next  = of_head_reg + OAW'(pop_out);
        of_level_next = of_level_reg + OLW'(rdv_reg) - OLW'(pop_out);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            of_head_reg  <= '0;
            of_level_reg <= '0;
        end
        else
        begin
            of_head_reg  <= of_head_next;
            of_level_reg <= of_level_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdv_reg)
        begin
            of_reg[of_tail].packet_byte    <= mem_q_reg;
            of_reg[of_tail].last_of_packet <= rdl_reg;
            of_reg[of_tail].good_packets   <= rdc_reg;
        end
    end

    assign out_valid = of_level_reg != '0;
    assign out_item  = of_reg[of_head_reg];

    a_no_read_ahead: assert property (@(posedge clk) disable iff (!rst_n)
        issue |-> (wr_ptr != rd_reg))
        else $error("drain read beyond written bytes");

    a_out_room: assert property (@(posedge clk) disable iff (!rst_n)
        rdv_reg |-> ((of_level_reg < OLW'(OUT_DEPTH)) || pop_out))
        else $error("read data arrived with output FIFO full");

endmodule

// ----- verif/sync_checksum_packet_framer_tb.sv -----
// Self-checking testbench for the sync/checksum packet framer.
module sync_checksum_packet_framer_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import scpf_pkg::*;

    localparam int FRAME_LEN = PACKET_BYTES_DEF;
    localparam int IDLE_PCT = 34;
    localparam int SETTLE_CYCLES = 12;
    localparam int HOLD_CYCLES = 500;
    localparam logic [7:0] SYNC_AT_RESET = 8'h00;
    localparam logic [7:0] ID_AT_RESET = 8'hA2;

    typedef logic [7:0] frame_t [FRAME_LEN];

    typedef enum int {
        FRAME_GOOD,
        FRAME_BAD_SYNC,
        FRAME_BAD_ID,
        FRAME_BAD_SUM,
        FRAME_CUT
    } frame_kind_t;

    // Window, register copies and the queue of packet bytes still owed by the block
    class framer_scoreboard;
        frame_t win;
        int unsigned fill;
        logic [31:0] good_count;
        logic [7:0] sync_byte;
        logic [7:0] id_byte;
        out_item_t expected_bytes [$];
        int unsigned errors;

        function new();
            fill = 0;
            good_count = '0;
            sync_byte = SYNC_AT_RESET;
            id_byte = ID_AT_RESET;
            errors = 0;
        endfunction

        // Wrapping sum of the little-endian words ahead of the checksum word
        static function logic [15:0] word_sum(frame_t f);
            logic [15:0] acc;
            acc = '0;
            for (int j = 0; j + 2 < FRAME_LEN; j += 2)
            begin
                acc += {f[j + 1], f[j]};
            end
            return acc;
        endfunction

        function void set_reg(reg_index_t idx, logic [7:0] value);
            case (idx)
                REG_SYNC_VALUE: sync_byte = value;
                REG_MESSAGE_ID: id_byte = value;
                default: ;
            endcase
        endfunction

        // Accepted input transfer: update the window, queue a packet if it verifies
        function void take_rx(in_item_t it);
            out_item_t r;
            if (it.overrun)
            begin
                fill = 0;
                return;
            end
            win[fill] = it.rx_byte;
            fill++;
            if (fill < FRAME_LEN)
                return;
            if (win[0] !== sync_byte || win[1] !== id_byte ||
                word_sum(win) !== {win[FRAME_LEN - 1], win[FRAME_LEN - 2]})
            begin
                // slide by one byte and search again
                for (int k = 0; k < FRAME_LEN - 1; k++)
                begin
                    win[k] = win[k + 1];
                end
                fill = FRAME_LEN - 1;
                return;
            end
            good_count++;
            for (int k = 0; k < FRAME_LEN; k++)
            begin
                r.packet_byte = win[k];
                r.last_of_packet = (k == FRAME_LEN - 1);
                r.good_packets = good_count;
                expected_bytes.push_back(r);
            end
            fill = 0;
        endfunction

        // Accepted output transfer: compare with the oldest owed byte
        function void check_packet_byte(out_item_t got);
            out_item_t want;
            if (expected_bytes.size() == 0)
            begin
                $display("%0t: unexpected output transfer: expected none, got %p", $time, got);
                errors++;
                return;
            end
            want = expected_bytes.pop_front();
            if (got.packet_byte !== want.packet_byte)
            begin
                $display("%0t: packet_byte: expected %02h, got %02h",
                         $time, want.packet_byte, got.packet_byte);
                errors++;
            end
            if (got.last_of_packet !== want.last_of_packet)
            begin
                $display("%0t: last_of_packet: expected %0b, got %0b",
                         $time, want.last_of_packet, got.last_of_packet);
                errors++;
            end
            if (got.good_packets !== want.good_packets)
            begin
                $display("%0t: good_packets: expected %0d, got %0d",
                         $time, want.good_packets, got.good_packets);
                errors++;
            end
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        in_valid = 1'b0;
    logic        in_ready;
    in_item_t    in_item = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    out_item_t   out_item;

    framer_scoreboard sb = new();
    bit          steady = 1'b0;
    int unsigned hold_left = 0;
    int unsigned rx_sent = 0;

    sync_checksum_packet_framer dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    // Output side: check each transfer, then choose ready for the next cycle
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (out_valid === 1'b1 && out_ready)
                sb.check_packet_byte(out_item);
            if (hold_left > 0)
            begin
                out_ready <= 1'b0;
                hold_left--;
            end
            else
                out_ready <= steady || ($urandom_range(99, 0) >= IDLE_PCT);
        end
    end

    // One input transfer, with an optional random gap ahead of it
    task automatic send_item(input in_item_t it);
        while (!steady && $urandom_range(99, 0) < IDLE_PCT)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item <= it;
        do
        begin
            @(posedge clk);
        end
        while (in_ready !== 1'b1);
        sb.take_rx(it);
        rx_sent++;
    endtask

    task automatic send_byte(input logic [7:0] b);
        send_item('{rx_byte: b, overrun: 1'b0});
    endtask

    task automatic send_overrun(input logic [7:0] junk);
        send_item('{rx_byte: junk, overrun: 1'b1});
    endtask

    // Frame built for the current registers, optionally spoilt or cut short
    task automatic send_frame(input frame_kind_t kind);
        frame_t f;
        logic [15:0] chk;
        int pos;
        int cut_at;
        f[0] = sb.sync_byte;
        f[1] = sb.id_byte;
        for (int k = 2; k < FRAME_LEN - 2; k++)
        begin
            f[k] = 8'($urandom_range(255, 0));
        end
        chk = framer_scoreboard::word_sum(f);
        f[FRAME_LEN - 2] = chk[7:0];
        f[FRAME_LEN - 1] = chk[15:8];
        // a single flipped bit always breaks the word sum
        pos = $urandom_range(FRAME_LEN - 1, 2);
        case (kind)
            FRAME_BAD_SYNC: f[0] = ~f[0];
            FRAME_BAD_ID:   f[1] = f[1] ^ 8'(1 << $urandom_range(7, 0));
            FRAME_BAD_SUM:  f[pos] = f[pos] ^ 8'(1 << $urandom_range(7, 0));
            default: ;
        endcase
        cut_at = (kind == FRAME_CUT) ? $urandom_range(FRAME_LEN - 2, 2) : FRAME_LEN;
        for (int k = 0; k < cut_at; k++)
        begin
            send_byte(f[k]);
        end
        if (kind == FRAME_CUT)
            send_overrun(8'($urandom_range(255, 0)));
    endtask

    // Mostly well-formed frames, with broken frames, noise and overruns mixed in
    task automatic random_traffic(input int unsigned target);
        int unsigned pick;
        int unsigned n;
        while (rx_sent < target)
        begin
            pick = $urandom_range(99, 0);
            if (pick < 60)
                send_frame(FRAME_GOOD);
            else if (pick < 66)
                send_frame(FRAME_BAD_SYNC);
            else if (pick < 72)
                send_frame(FRAME_BAD_ID);
            else if (pick < 78)
                send_frame(FRAME_BAD_SUM);
            else if (pick < 84)
                send_frame(FRAME_CUT);
            else if (pick < 94)
            begin
                n = $urandom_range(8, 1);
                repeat (n) send_byte(8'($urandom_range(255, 0)));
            end
            else
                send_overrun(8'($urandom_range(255, 0)));
        end
    endtask

    // Hold the sender until every owed byte has arrived and the pipeline is quiet
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (sb.expected_bytes.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic reg_readback(input reg_index_t idx);
        logic [7:0] want;
        want = (idx == REG_SYNC_VALUE) ? sb.sync_byte : sb.id_byte;
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= {idx, 2'b00};
        @(posedge clk);
        penable <= 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (pready !== 1'b1);
        if (prdata[7:0] !== want)
        begin
            $display("%0t: register %s readback: expected %02h, got %02h",
                     $time, idx.name(), want, prdata[7:0]);
            sb.errors++;
        end
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    // Register write (setup, then access), followed by a readback
    task automatic reg_write(input reg_index_t idx, input logic [7:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= {24'h0, value};
        @(posedge clk);
        penable <= 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (pready !== 1'b1);
        sb.set_reg(idx, value);
        reg_readback(idx);
    endtask

    // Stimulus
    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        reg_readback(REG_SYNC_VALUE);
        reg_readback(REG_MESSAGE_ID);

        // directed: byte extremes, overruns, partial window thrown away
        send_byte(8'h00);
        send_byte(8'hFF);
        send_overrun(8'hFF);
        send_overrun(8'h00);
        send_byte(SYNC_AT_RESET);
        send_byte(ID_AT_RESET);
        send_byte(8'h55);
        send_byte(8'hAA);
        send_overrun(8'h5A);
        send_frame(FRAME_GOOD);

        // reset register values
        random_traffic(120);
        wait_drained();

        // high sync, low id; output held off while frames keep coming
        reg_write(REG_SYNC_VALUE, 8'hFF);
        reg_write(REG_MESSAGE_ID, 8'h00);
        steady = 1'b1;
        hold_left = HOLD_CYCLES;
        repeat (4) send_frame(FRAME_GOOD);
        random_traffic(320);
        steady = 1'b0;
        wait_drained();

        // low sync, high id
        reg_write(REG_SYNC_VALUE, 8'h00);
        reg_write(REG_MESSAGE_ID, 8'hFF);
        random_traffic(400);
        wait_drained();

        // arbitrary registers
        reg_write(REG_SYNC_VALUE, 8'($urandom_range(255, 0)));
        reg_write(REG_MESSAGE_ID, 8'($urandom_range(255, 0)));
        random_traffic(470);
        wait_drained();

        if (sb.errors == 0)
            $display("sync_checksum_packet_framer regression: pass");
        else
            $display("sync_checksum_packet_framer regression: fail");
        $finish;
    end

    // Watchdog
    initial
    begin
        #2ms;
        $display("sync_checksum_packet_framer regression: fail");
        $finish;
    end

endmodule
